>>> rtl/lms_adaptive_fir_defines.svh
// Assertion macros for the LMS adaptive FIR block.
`ifndef LMS_ADAPTIVE_FIR_DEFINES_SVH
`define LMS_ADAPTIVE_FIR_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LMSAF_ASSERT_IMP(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
        else $error("lmsaf: same-cycle check failed");
// next-cycle implication
`define LMSAF_ASSERT_NXT(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
        else $error("lmsaf: next-cycle check failed");
`else
`define LMSAF_ASSERT_IMP(lbl, ck, rn, a, c)
`define LMSAF_ASSERT_NXT(lbl, ck, rn, a, c)
`endif
`endif

>>> rtl/lmsaf_pkg.sv
package lmsaf_pkg;

    localparam int TAPS     = 10;
    localparam int TAP_IW   = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int SAMPLE_W = 16;
    localparam int W_W      = 48;
    localparam int FRAC     = 40;
    localparam int STEP_W   = 32;

    localparam logic [STEP_W-1:0] STEP_RESET = 32'd7205759;

    // Sized for TAPS up to 128: |error| < 2^70 in Q40.
    localparam int ECH_W   = 24;                 // error magnitude chunk
    localparam int EMAG_W  = 3 * ECH_W;
    localparam int ERR_W   = EMAG_W + 1;
    localparam int E_W     = EMAG_W + STEP_W;    // |error| * step
    localparam int UCH_W   = (E_W + 2) / 3;      // chunk of that product
    localparam int E_REG_W = 3 * UCH_W;
    localparam int WCH_W   = W_W / 2;            // weight magnitude chunk
    localparam int MA_W    = UCH_W;
    localparam int MB_W    = STEP_W;
    localparam int P_W     = MA_W + MB_W;
    localparam int ACC_W   = E_W + SAMPLE_W;
    localparam int UPD_SH  = 56;
    localparam int D_W     = 62;
    localparam int NW_W    = 64;
    localparam int Q_W     = ERR_W - FRAC + 1;

    localparam logic signed [W_W-1:0] W_MAX = {1'b0, {(W_W-1){1'b1}}};
    localparam logic signed [W_W-1:0] W_MIN = {1'b1, {(W_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [Q_W-1:0] Q_HI = Q_W'(32767);
    localparam logic signed [Q_W-1:0] Q_LO = Q_W'(-32768);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic signed [SAMPLE_W-1:0] desired;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filter_out;
        logic signed [SAMPLE_W-1:0] error_out;
    } out_word_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_W_LO,
        MUL_W_HI,
        MUL_E0,
        MUL_E1,
        MUL_E2,
        MUL_U0,
        MUL_U1,
        MUL_U2
    } mul_op_t;

    typedef enum logic [2:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_NO_IN,
        JC_MORE_TAPS,
        JC_OUT_BUSY
    } jump_cond_t;

    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t UA_IDLE    = 5'd0;
    localparam upc_t UA_FLT_LO  = 5'd1;
    localparam upc_t UA_FLT_HI  = 5'd2;
    localparam upc_t UA_FLT_DRN = 5'd3;
    localparam upc_t UA_ERR     = 5'd4;
    localparam upc_t UA_OUT     = 5'd5;
    localparam upc_t UA_E0      = 5'd6;
    localparam upc_t UA_E1      = 5'd7;
    localparam upc_t UA_E2      = 5'd8;
    localparam upc_t UA_E_DRN   = 5'd9;
    localparam upc_t UA_E_LD    = 5'd10;
    localparam upc_t UA_U0      = 5'd11;
    localparam upc_t UA_U1      = 5'd12;
    localparam upc_t UA_U2      = 5'd13;
    localparam upc_t UA_U_DRN   = 5'd14;
    localparam upc_t UA_U_WR    = 5'd15;
    localparam upc_t UA_END     = 5'd16;

    typedef struct packed {
        logic       take_in;
        mul_op_t    mul_op;
        logic       acc_clr;
        logic       k_clr;
        logic       k_inc;
        logic       ld_err;
        logic       ld_out;
        logic       ld_emag;
        logic       ld_e;
        logic       wr_w;
        jump_cond_t jc;
        upc_t       target;
    } cw_t;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic more_taps;
    } seq_stat_t;

    typedef struct packed {
        logic out_busy;
        logic more_taps;
    } dp_stat_t;

    localparam cw_t CW_NOP = '{
        take_in: 1'b0, mul_op: MUL_NONE, acc_clr: 1'b0, k_clr: 1'b0, k_inc: 1'b0,
        ld_err: 1'b0, ld_out: 1'b0, ld_emag: 1'b0, ld_e: 1'b0, wr_w: 1'b0,
        jc: JC_NEXT, target: UA_IDLE
    };

    // Microprogram. A product issued in one step is accumulated in the next.
    function automatic cw_t ucode_rom(input upc_t addr);
        cw_t cw;
        cw = CW_NOP;
        unique case (addr)
            UA_IDLE: begin
                cw.take_in = 1'b1;
                cw.acc_clr = 1'b1;
                cw.k_clr   = 1'b1;
                cw.jc      = JC_NO_IN;
                cw.target  = UA_IDLE;
            end
            UA_FLT_LO: cw.mul_op = MUL_W_LO;
            UA_FLT_HI: begin
                cw.mul_op = MUL_W_HI;
                cw.k_inc  = 1'b1;
                cw.jc     = JC_MORE_TAPS;
                cw.target = UA_FLT_LO;
            end
            UA_FLT_DRN: cw = CW_NOP;
            UA_ERR:     cw.ld_err = 1'b1;
            UA_OUT: begin
                cw.ld_out  = 1'b1;
                cw.ld_emag = 1'b1;
                cw.acc_clr = 1'b1;
                cw.jc      = JC_OUT_BUSY;
                cw.target  = UA_OUT;
            end
            UA_E0:    cw.mul_op = MUL_E0;
            UA_E1:    cw.mul_op = MUL_E1;
            UA_E2:    cw.mul_op = MUL_E2;
            UA_E_DRN: cw = CW_NOP;
            UA_E_LD: begin
                cw.ld_e    = 1'b1;
                cw.acc_clr = 1'b1;
                cw.k_clr   = 1'b1;
            end
            UA_U0:    cw.mul_op = MUL_U0;
            UA_U1:    cw.mul_op = MUL_U1;
            UA_U2:    cw.mul_op = MUL_U2;
            UA_U_DRN: cw = CW_NOP;
            UA_U_WR: begin
                cw.wr_w    = 1'b1;
                cw.acc_clr = 1'b1;
                cw.k_inc   = 1'b1;
                cw.jc      = JC_MORE_TAPS;
                cw.target  = UA_U0;
            end
            UA_END: begin
                cw.jc     = JC_ALWAYS;
                cw.target = UA_IDLE;
            end
            default: begin
                cw.jc     = JC_ALWAYS;
                cw.target = UA_IDLE;
            end
        endcase
        return cw;
    endfunction

    // Q40 value, truncated toward zero, saturated to 16 bits.
    function automatic logic signed [SAMPLE_W-1:0] sat_q40(input logic [ERR_W-1:0] v);
        logic [Q_W-1:0]             q;
        logic                       rnd;
        logic signed [SAMPLE_W-1:0] r;
        rnd = v[ERR_W-1] & (|v[FRAC-1:0]);
        q   = {v[ERR_W-1], v[ERR_W-1:FRAC]} + Q_W'(rnd);
        if ($signed(q) > Q_HI) begin
            r = S_MAX;
        end
        else if ($signed(q) < Q_LO) begin
            r = S_MIN;
        end
        else begin
            r = q[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/lms_adaptive_fir.sv
// LMS adaptive FIR, TAPS = 10, one word in and one word out per item.
// out_valid rises after the filter, drain, error and output-load steps. A new word is
// taken only after the update ends, as all steps share the one 35x32 multiplier:
// two passes per tap for the output, three per tap plus drain and write for the update.
// Reset: taps and weights clear to zero and step_size loads 7205759 at once;
// there is no clearing pass, the block accepts a word in the first cycle after reset.
`include "lms_adaptive_fir_defines.svh"

module lms_adaptive_fir
    import lmsaf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_word_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_word_t         out_data,
    input  logic              cfg_wr_en,
    input  logic [STEP_W-1:0] cfg_wr_data
);

    // Control word from the microprogram ROM, status back to the sequencer.
    cw_t       cw;
    dp_stat_t  dp_stat;
    seq_stat_t seq_stat;

    // Only the idle step takes a word. The sequencer loops there until one
    // arrives. The output register holds the previous word while the next item
    // is computed; the output-load step waits while that register is still full.
    assign in_stall = ~cw.take_in;

    always_comb begin
        seq_stat.in_valid  = in_valid;
        seq_stat.out_busy  = dp_stat.out_busy;
        seq_stat.more_taps = dp_stat.more_taps;
    end

    // Sequencer: step counter plus ROM. Program outline:
    //   idle/accept -> per tap: |w| low and high halves times |x| into the
    //   accumulator -> error = desired*2^40 - sum -> load output word (waits
    //   here while the output register is still full) -> |error| * step in
    //   three chunks -> per tap: that product times |x| in three chunks,
    //   bits 56 and up are the weight step, signed and saturated into w.
    lmsaf_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (seq_stat),
        .cw    (cw)
    );

    // Datapath: tap line, weights, step register, multiplier with a product
    // register, one wide accumulator shared by all three phases, output word.
    lmsaf_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cw          (cw),
        .in_valid    (in_valid),
        .in_data     (in_data),
        .out_stall   (out_stall),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (out_valid),
        .out_data    (out_data),
        .stat        (dp_stat)
    );

    // A result appears only right after the output-load step.
    `LMSAF_ASSERT_IMP(a_out_from_load, clk, rst_n, $rose(out_valid), $past(cw.ld_out))
    // The load step waits in place while the output register is held.
    `LMSAF_ASSERT_NXT(a_load_waits, clk, rst_n, cw.ld_out && out_valid && out_stall, cw.ld_out)
    // After taking a word the sequencer leaves the idle step.
    `LMSAF_ASSERT_NXT(a_leave_idle, clk, rst_n, in_valid && !in_stall, !cw.take_in)

endmodule

>>> rtl/lmsaf_useq.sv
module lmsaf_useq
    import lmsaf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  seq_stat_t stat,
    output cw_t       cw
);

    upc_t upc_reg;
    upc_t upc_next;
    logic taken;

    always_comb begin
        cw = ucode_rom(upc_reg);
    end

    always_comb begin
        unique case (cw.jc)
            JC_NEXT:      taken = 1'b0;
            JC_ALWAYS:    taken = 1'b1;
            JC_NO_IN:     taken = ~stat.in_valid;
            JC_MORE_TAPS: taken = stat.more_taps;
            JC_OUT_BUSY:  taken = stat.out_busy;
            default:      taken = 1'b0;
        endcase
        upc_next = taken ? cw.target : UPC_W'(upc_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            upc_reg <= UA_IDLE;
        end
        else begin
            upc_reg <= upc_next;
        end
    end

endmodule

>>> rtl/lmsaf_dpath.sv
module lmsaf_dpath
    import lmsaf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cw_t               cw,
    input  logic              in_valid,
    input  in_word_t          in_data,
    input  logic              out_stall,
    input  logic              cfg_wr_en,
    input  logic [STEP_W-1:0] cfg_wr_data,
    output logic              out_valid,
    output out_word_t         out_data,
    output dp_stat_t          stat
);

    logic signed [SAMPLE_W-1:0] tap_reg [TAPS];
    logic signed [W_W-1:0]      w_reg   [TAPS];
    logic [STEP_W-1:0]          step_reg;
    logic [TAP_IW-1:0]          k_reg;
    logic [TAP_IW-1:0]          k_next;
    logic                       out_valid_reg;
    out_word_t                  out_reg;
    logic signed [SAMPLE_W-1:0] desired_reg;

    mul_op_t                    mul_op_reg;
    logic                       prod_neg_reg;
    logic [P_W-1:0]             prod_reg;
    logic [ACC_W-1:0]           acc_reg;
    logic [ACC_W-1:0]           acc_next;
    logic [ERR_W-1:0]           err_reg;
    logic signed [SAMPLE_W-1:0] fout_reg;
    logic [EMAG_W-1:0]          emag_reg;
    logic                       eneg_reg;
    logic [E_REG_W-1:0]         e_reg;

    logic                       take;
    logic                       load_out;
    logic                       more_taps;
    logic signed [W_W-1:0]      w_sel;
    logic signed [SAMPLE_W-1:0] t_sel;
    logic                       w_neg;
    logic                       t_neg;
    logic [W_W-1:0]             w_mag;
    logic [SAMPLE_W-1:0]        t_mag;
    logic [MA_W-1:0]            mul_a;
    logic [MB_W-1:0]            mul_b;
    logic                       mul_neg;
    logic [ACC_W-1:0]           addend;
    logic [ERR_W-1:0]           ds_q;
    logic [ERR_W-1:0]           err_abs;
    logic [D_W-1:0]             d_mag;
    logic                       d_neg;
    logic [NW_W-1:0]            d_ext;
    logic [NW_W-1:0]            nw;
    logic                       nw_fits;
    logic signed [W_W-1:0]      w_new;

    assign take      = cw.take_in & in_valid;
    assign load_out  = cw.ld_out & ~(out_valid_reg & out_stall);
    assign more_taps = (k_reg != TAP_IW'(TAPS - 1));

    assign stat.out_busy  = out_valid_reg & out_stall;
    assign stat.more_taps = more_taps;
    assign out_valid      = out_valid_reg;
    assign out_data       = out_reg;

    always_comb begin
        if (cw.k_clr) begin
            k_next = '0;
        end
        else if (cw.k_inc) begin
            k_next = more_taps ? TAP_IW'(k_reg + 1'b1) : '0;
        end
        else begin
            k_next = k_reg;
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        w_sel = w_reg[k_reg];
        t_sel = tap_reg[k_reg];
        w_neg = w_sel[W_W-1];
        t_neg = t_sel[SAMPLE_W-1];
        w_mag = w_neg ? (~w_sel + 1'b1) : w_sel;
        t_mag = t_neg ? (~t_sel + 1'b1) : t_sel;
        unique case (cw.mul_op)
            MUL_W_LO: begin
                mul_a   = MA_W'(w_mag[WCH_W-1:0]);
                mul_b   = MB_W'(t_mag);
                mul_neg = w_neg ^ t_neg;
            end
            MUL_W_HI: begin
                mul_a   = MA_W'(w_mag[W_W-1:WCH_W]);
                mul_b   = MB_W'(t_mag);
                mul_neg = w_neg ^ t_neg;
            end
            MUL_E0: begin
                mul_a   = MA_W'(emag_reg[ECH_W-1:0]);
                mul_b   = step_reg;
                mul_neg = 1'b0;
            end
            MUL_E1: begin
                mul_a   = MA_W'(emag_reg[2*ECH_W-1:ECH_W]);
                mul_b   = step_reg;
                mul_neg = 1'b0;
            end
            MUL_E2: begin
                mul_a   = MA_W'(emag_reg[3*ECH_W-1:2*ECH_W]);
                mul_b   = step_reg;
                mul_neg = 1'b0;
            end
            MUL_U0: begin
                mul_a   = e_reg[UCH_W-1:0];
                mul_b   = MB_W'(t_mag);
                mul_neg = 1'b0;
            end
            MUL_U1: begin
                mul_a   = e_reg[2*UCH_W-1:UCH_W];
                mul_b   = MB_W'(t_mag);
                mul_neg = 1'b0;
            end
            MUL_U2: begin
                mul_a   = e_reg[3*UCH_W-1:2*UCH_W];
                mul_b   = MB_W'(t_mag);
                mul_neg = 1'b0;
            end
            default: begin
                mul_a   = '0;
                mul_b   = '0;
                mul_neg = 1'b0;
            end
        endcase
    end

    // accumulate the registered product at its weight
    always_comb begin
        unique case (mul_op_reg)
            MUL_W_HI: addend = ACC_W'(prod_reg) << WCH_W;
            MUL_E1:   addend = ACC_W'(prod_reg) << ECH_W;
            MUL_E2:   addend = ACC_W'(prod_reg) << (2 * ECH_W);
            MUL_U1:   addend = ACC_W'(prod_reg) << UCH_W;
            MUL_U2:   addend = ACC_W'(prod_reg) << (2 * UCH_W);
            default:  addend = ACC_W'(prod_reg);
        endcase
        if (cw.acc_clr) begin
            acc_next = '0;
        end
        else if (mul_op_reg != MUL_NONE) begin
            acc_next = acc_reg + (addend ^ {ACC_W{prod_neg_reg}}) + ACC_W'(prod_neg_reg);
        end
        else begin
            acc_next = acc_reg;
        end
    end

    // error, its magnitude, and the weight update
    always_comb begin
        ds_q    = {{(ERR_W-SAMPLE_W-FRAC){desired_reg[SAMPLE_W-1]}}, desired_reg,
                   {FRAC{1'b0}}};
        err_abs = err_reg[ERR_W-1] ? (~err_reg + 1'b1) : err_reg;
        d_mag   = acc_reg[UPD_SH+D_W-1:UPD_SH];
        d_neg   = eneg_reg ^ t_neg;
        d_ext   = d_neg ? (~NW_W'(d_mag) + 1'b1) : NW_W'(d_mag);
        nw      = {{(NW_W-W_W){w_sel[W_W-1]}}, w_sel} + d_ext;
        nw_fits = (&nw[NW_W-1:W_W-1]) | ~(|nw[NW_W-1:W_W-1]);
        if (nw_fits) begin
            w_new = nw[W_W-1:0];
        end
        else begin
            w_new = nw[NW_W-1] ? W_MIN : W_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                tap_reg[i] <= '0;
                w_reg[i]   <= '0;
            end
            step_reg      <= STEP_RESET;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            mul_op_reg    <= MUL_NONE;
            prod_neg_reg  <= 1'b0;
        end
        else begin
            if (take) begin
                tap_reg[0] <= in_data.sample_in;
                for (int i = 1; i < TAPS; i++) begin
                    tap_reg[i] <= tap_reg[i-1];
                end
            end
            if (cw.wr_w) begin
                w_reg[k_reg] <= w_new;
            end
            if (cfg_wr_en) begin
                step_reg <= cfg_wr_data;
            end
            k_reg         <= k_next;
            out_valid_reg <= load_out | (out_valid_reg & out_stall);
            mul_op_reg    <= cw.mul_op;
            prod_neg_reg  <= mul_neg;
        end
    end

    always_ff @(posedge clk) begin
        prod_reg <= P_W'(mul_a) * P_W'(mul_b);
        acc_reg  <= acc_next;
        if (take) begin
            desired_reg <= in_data.desired;
        end
        if (cw.ld_err) begin
            err_reg  <= ds_q - acc_reg[ERR_W-1:0];
            fout_reg <= sat_q40(acc_reg[ERR_W-1:0]);
        end
        if (cw.ld_emag) begin
            emag_reg <= err_abs[EMAG_W-1:0];
            eneg_reg <= err_reg[ERR_W-1];
        end
        if (cw.ld_e) begin
            e_reg <= acc_reg[E_REG_W-1:0];
        end
        if (load_out) begin
            out_reg <= '{filter_out: fout_reg, error_out: sat_q40(err_reg)};
        end
    end

endmodule

>>> tb/sv/testbench.sv
module testbench;
    import lmsaf_pkg::*;

    // Run length and timing budget. One word costs its full pass through the block,
    // plus any sender gap and receiver stall. About 520 words in all, so the slowest
    // good run stays well inside the watchdog limit.
    localparam int CYCLE_LIMIT   = 400000;
    // The output leaves at the output-load step, but the weight update keeps running
    // after it. Wait this long before a step write and at the end of the run.
    localparam int SETTLE_CYCLES = 100;
    localparam int N_PHASES      = 9;
    localparam int PHASE_WORDS   = 55;
    localparam int MAX_REPORTS   = 10;

    // ------------------------------------------------------------------
    // Predictor and output check. Holds its own delay line, weights and
    // step, updated once per accepted input word.
    // ------------------------------------------------------------------
    class adapt_checker;
        logic signed [SAMPLE_W-1:0] delay_line[TAPS];
        logic signed [W_W-1:0]      coef[TAPS];
        logic [STEP_W-1:0]          mu;
        out_word_t                  expected_outputs[$];
        int                         mismatch_count;

        function new();
            for (int k = 0; k < TAPS; k++)
            begin
                delay_line[k] = '0;
                coef[k]       = '0;
            end
            mu             = STEP_RESET;
            mismatch_count = 0;
        endfunction

        function void set_step(logic [STEP_W-1:0] v);
            mu = v;
        endfunction

        // Q40 value truncated toward zero, clipped to 16-bit PCM.
        function logic signed [SAMPLE_W-1:0] to_pcm(logic signed [127:0] v);
            logic [127:0]               mag;
            logic [127:0]               q;
            logic signed [SAMPLE_W-1:0] r;
            mag = v[127] ? 128'(-v) : 128'(v);
            q   = mag >> FRAC;
            if (v[127])
            begin
                r = (q > 128'd32768) ? S_MIN : -q[SAMPLE_W-1:0];
            end
            else
            begin
                r = (q > 128'd32767) ? S_MAX : q[SAMPLE_W-1:0];
            end
            return r;
        endfunction

        function void take_sample(in_word_t w);
            logic signed [127:0] acc;
            logic signed [127:0] err;
            logic [127:0]        emag;
            logic [127:0]        prod;
            logic                eneg;
            logic                tneg;
            logic signed [31:0]  tval;
            logic [31:0]         tmag;
            logic signed [63:0]  delta;
            logic signed [63:0]  grown;
            out_word_t           want;
            int                  k;

            for (k = TAPS - 1; k > 0; k--)
                delay_line[k] = delay_line[k-1];
            delay_line[0] = w.sample_in;

            // exact dot product, Q40
            acc = '0;
            for (k = 0; k < TAPS; k++)
                acc = acc + coef[k] * delay_line[k];

            err = $signed(w.desired);
            err = (err <<< FRAC) - acc;

            want.filter_out = to_pcm(acc);
            want.error_out  = to_pcm(err);
            expected_outputs.push_back(want);

            // weight step: |e| * |x| * mu >> 56, then signed, then clipped
            eneg = err[127];
            emag = eneg ? 128'(-err) : 128'(err);
            for (k = 0; k < TAPS; k++)
            begin
                tval  = delay_line[k];
                tneg  = tval[31];
                tmag  = tneg ? -tval : tval;
                prod  = emag * tmag * mu;
                delta = $signed({2'b00, prod[117:56]});
                if (eneg != tneg)
                    delta = -delta;
                grown = coef[k] + delta;
                if (grown > W_MAX)
                    coef[k] = W_MAX;
                else if (grown < W_MIN)
                    coef[k] = W_MIN;
                else
                    coef[k] = grown[W_W-1:0];
            end
        endfunction

        function void note_mismatch(string what, logic signed [SAMPLE_W-1:0] want,
                                    logic signed [SAMPLE_W-1:0] got);
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        endfunction

        function void check_output(out_word_t got);
            out_word_t want;
            if (expected_outputs.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("output word with nothing pending: filter_out %0d error_out %0d",
                             got.filter_out, got.error_out);
                return;
            end
            want = expected_outputs.pop_front();
            if (got.filter_out !== want.filter_out)
                note_mismatch("filter_out", want.filter_out, got.filter_out);
            if (got.error_out !== want.error_out)
                note_mismatch("error_out", want.error_out, got.error_out);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Block hookup
    // ------------------------------------------------------------------
    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    in_word_t          in_data;
    logic              out_valid;
    logic              out_stall;
    out_word_t         out_data;
    logic              cfg_wr_en;
    logic [STEP_W-1:0] cfg_wr_data;

    adapt_checker sb = new();

    // Random gaps and stalls are on while this is set; off for the final
    // phase and for one stretch in the middle.
    bit                         idle_on;
    logic signed [SAMPLE_W-1:0] last_x;

    lms_adaptive_fir i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Monitors. All inputs change by NBA at the edge, so reading here gives
    // the values the block saw at this edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.take_sample(in_data);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_output(out_data);
    end

    // Receiver: random stall bursts while idling is enabled.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!idle_on)
            begin
                stall_left = 0;
                out_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 4);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Present one word and hold it until accepted. An optional gap with valid
    // low comes first; otherwise valid stays high from the previous word.
    task automatic send_word(input in_word_t w);
        int gap;
        if (idle_on && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drain everything and let the weight update finish; write_step then writes the step.
    task automatic drain_block();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_outputs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_step(input logic [STEP_W-1:0] v);
        drain_block();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_step(v);
    endtask

    // Mostly full-range noise, with rails, zero, -1 and low-level samples
    // mixed in so that saturation and small updates both show up.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] s;
        case ($urandom_range(0, 9))
            0:       s = S_MAX;
            1:       s = S_MIN;
            2:       s = '0;
            3:       s = -16'sd1;
            4, 5:    s = $signed(16'($urandom_range(0, 511))) - 16'sd256;
            default: s = 16'($urandom);
        endcase
        return s;
    endfunction

    // Most words follow a simple plant (desired is half the previous input),
    // which gives the filter something it can actually learn; the rest is
    // unrelated noise on the desired side.
    function automatic in_word_t next_word();
        in_word_t w;
        w.sample_in = pick_sample();
        if ($urandom_range(0, 2) == 0)
            w.desired = pick_sample();
        else
            w.desired = last_x >>> 1;
        last_x = w.sample_in;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [STEP_W-1:0] plan[N_PHASES];
        int                p;
        int                i;

        idle_on     = 1'b1;
        last_x      = '0;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        in_data     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Startup at the reset step: delay line still filling with zeros,
        // weights zero, so the first outputs are zero and error equals desired.
        send_word(in_word_t'{16'sd0, 16'sd0});
        send_word(in_word_t'{S_MAX, S_MAX});
        send_word(in_word_t'{S_MIN, S_MIN});
        send_word(in_word_t'{S_MAX, S_MIN});
        send_word(in_word_t'{S_MIN, S_MAX});
        send_word(in_word_t'{16'sd1, -16'sd1});
        send_word(in_word_t'{-16'sd1, 16'sd1});
        send_word(in_word_t'{16'sd0, S_MAX});
        send_word(in_word_t'{16'sd0, S_MIN});
        send_word(in_word_t'{16'sh5555, 16'shAAAA});
        send_word(in_word_t'{16'shAAAA, 16'sh5555});
        send_word(in_word_t'{16'sd0, 16'sd0});

        // Largest step with full-scale input: the loop goes unstable within a
        // few words, pushing output, error and weights into saturation.
        write_step('1);
        for (i = 0; i < 10; i++)
            send_word(in_word_t'{(i % 2 == 1) ? S_MIN : S_MAX, S_MAX});

        // Random phases over a spread of step values: frozen, tiny, stable
        // adaptation, divergent, and random.
        plan[0] = '0;
        plan[1] = 32'd1;
        plan[2] = 32'h0100_0000;
        plan[3] = '1;
        plan[4] = $urandom;
        plan[5] = STEP_RESET;
        plan[6] = 32'h0080_0000;
        plan[7] = $urandom_range(0, 32'h0400_0000);
        plan[8] = 32'h0100_0000;

        for (p = 0; p < N_PHASES; p++)
        begin
            write_step(plan[p]);
            idle_on = (p != 3) && (p != N_PHASES - 1);
            for (i = 0; i < PHASE_WORDS; i++)
                send_word(next_word());
        end

        drain_block();

        if (sb.mismatch_count == 0 && sb.expected_outputs.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
